/* src/bank_switched_memory_decoder_defines.svh */
// ----------------------------------------------------------------------------
// Bank-switched memory decoder: assertion macros
// Shared property forms for the checks at the end of the top RTL module.
// ----------------------------------------------------------------------------
`ifndef BANK_SWITCHED_MEMORY_DECODER_DEFINES_SVH
`define BANK_SWITCHED_MEMORY_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BSMD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("bsmd check failed");

// Next-cycle implication, checked out of reset.
`define BSMD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("bsmd check failed");

`endif

/* src/bsmd_pkg.sv */
// ----------------------------------------------------------------------------
// bsmd_pkg
// Types, region codes, register indexes and soft-switch addresses.
// ----------------------------------------------------------------------------
package bsmd_pkg;

    localparam int CFG_IDX_W = 3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AUX_ZERO_PAGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUX_READ      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUX_WRITE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_RAM_READ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK2_SELECT  = 3'd4;

    // target regions
    localparam logic [2:0] RGN_MAIN   = 3'd0;
    localparam logic [2:0] RGN_AUX    = 3'd1;
    localparam logic [2:0] RGN_ROM    = 3'd2;
    localparam logic [2:0] RGN_SLOT   = 3'd3;
    localparam logic [2:0] RGN_BANK1  = 3'd4;
    localparam logic [2:0] RGN_BANK2  = 3'd5;
    localparam logic [2:0] RGN_SWITCH = 3'd6;

    localparam logic REQ_WRITE = 1'b1;

    // soft-switch write addresses (low bit is the new flag value)
    localparam logic [15:0] SW_STORE80_OFF = 16'hC000;
    localparam logic [15:0] SW_STORE80_ON  = 16'hC001;
    localparam logic [15:0] SW_COL80_OFF   = 16'hC00C;
    localparam logic [15:0] SW_COL80_ON    = 16'hC00D;
    localparam logic [15:0] SW_ALTCH_OFF   = 16'hC00E;
    localparam logic [15:0] SW_ALTCH_ON    = 16'hC00F;
    localparam logic [15:0] SW_TEXT_OFF    = 16'hC050;
    localparam logic [15:0] SW_TEXT_ON     = 16'hC051;
    localparam logic [15:0] SW_MIXED_OFF   = 16'hC052;
    localparam logic [15:0] SW_MIXED_ON    = 16'hC053;
    localparam logic [15:0] SW_PAGE2_OFF   = 16'hC054;
    localparam logic [15:0] SW_PAGE2_ON    = 16'hC055;
    localparam logic [15:0] SW_HIRES_OFF   = 16'hC056;
    localparam logic [15:0] SW_HIRES_ON    = 16'hC057;

    // soft-switch status reads
    localparam logic [15:0] RD_VBLANK = 16'hC019;
    localparam logic [15:0] RD_TEXT   = 16'hC01A;
    localparam logic [15:0] RD_MIXED  = 16'hC01B;
    localparam logic [15:0] RD_ALTCH  = 16'hC01E;

    localparam logic [7:0] STATUS_BIT = 8'h80;

    typedef struct packed {
        logic        req_type;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  vblank_status;
    } t_item;

    typedef struct packed {
        logic aux_zero_page;
        logic aux_read;
        logic aux_write;
        logic bank_ram_read;
        logic bank2_select;
    } t_cfg;

    typedef struct packed {
        logic store80;
        logic text_mode;
        logic mixed_mode;
        logic page2;
        logic hires;
        logic col80;
        logic altchar;
    } t_flags;

    typedef struct packed {
        logic [2:0] region;
        logic [7:0] mem_wdata;
        logic [7:0] sw_rdata;
    } t_result;

endpackage

/* src/bank_switched_memory_decoder.sv */
// Path: an accepted item is held in the input register, then in the result register that drives the outputs.
// Throughput: one item per cycle while i_stall is low; the decode is a single pass between the registers.
// Display flags update in the cycle an item moves from the input to the result register.
// Reset (synchronous, active low) clears both valid bits, all config registers and the state flags.
// ----------------------------------------------------------------------------
// bank_switched_memory_decoder
// Bus access decoder with config switches and display soft-switch flags.
// ----------------------------------------------------------------------------
`include "bank_switched_memory_decoder_defines.svh"

module bank_switched_memory_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_vblank_status,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_target_region,
    output logic [7:0]  o_mem_write_data,
    output logic [7:0]  o_switch_read_data,
    output logic        o_store80_flag,
    output logic        o_text_flag,
    output logic        o_mixed_flag,
    output logic        o_page2_flag,
    output logic        o_hires_flag,
    output logic        o_col80_flag,
    output logic        o_altchar_flag,
    input  logic        i_cfg_we,
    input  logic [bsmd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        i_cfg_wdata
);
    import bsmd_pkg::*;

    logic    r_in_vld;
    logic    n_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    logic    n_out_vld;
    t_result r_res;
    t_flags  r_out_flags;

    logic    w_out_rdy;
    logic    w_fire;
    logic    w_in_acc;
    t_cfg    w_cfg;
    t_flags  w_flags;
    t_flags  w_flags_nxt;
    t_result w_res;

    assign w_out_rdy = !r_out_vld || !i_stall;
    assign w_fire    = r_in_vld && w_out_rdy;
    assign o_stall   = r_in_vld && !w_out_rdy;
    assign w_in_acc  = i_valid && !o_stall;

    assign n_in_vld  = w_in_acc || (r_in_vld && !w_fire);
    assign n_out_vld = w_fire || (r_out_vld && i_stall);

    bsmd_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_update    (w_fire),
        .i_flags_nxt (w_flags_nxt),
        .o_cfg       (w_cfg),
        .o_flags     (w_flags)
    );

    bsmd_decode u_decode (
        .i_item      (r_in),
        .i_cfg       (w_cfg),
        .i_flags     (w_flags),
        .o_result    (w_res),
        .o_flags_nxt (w_flags_nxt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in.req_type      <= i_req_type;
            r_in.address       <= i_address;
            r_in.write_data    <= i_write_data;
            r_in.vblank_status <= i_vblank_status;
        end
        if (w_fire) begin
            r_res       <= w_res;
            r_out_flags <= w_flags_nxt;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_target_region    = r_res.region;
    assign o_mem_write_data   = r_res.mem_wdata;
    assign o_switch_read_data = r_res.sw_rdata;
    assign o_store80_flag     = r_out_flags.store80;
    assign o_text_flag        = r_out_flags.text_mode;
    assign o_mixed_flag       = r_out_flags.mixed_mode;
    assign o_page2_flag       = r_out_flags.page2;
    assign o_hires_flag       = r_out_flags.hires;
    assign o_col80_flag       = r_out_flags.col80;
    assign o_altchar_flag     = r_out_flags.altchar;

    // flags only move when an item passes through the decode
    `BSMD_ASSERT_NXT(a_flags_hold, !w_fire, $stable(w_flags))
    // backpressure only when an item is held at the input register
    `BSMD_ASSERT_IMP(a_stall_has_item, o_stall, r_in_vld)
    // soft-switch accesses never forward a byte to memory
    `BSMD_ASSERT_IMP(a_sw_no_wdata, o_valid && (o_target_region == RGN_SWITCH),
        o_mem_write_data == 8'h00)
    // a nonzero read value only comes from the soft-switch page
    `BSMD_ASSERT_IMP(a_rdata_sw_only, o_valid && (o_switch_read_data != 8'h00),
        o_target_region == RGN_SWITCH)

endmodule

/* src/bsmd_state.sv */
// ----------------------------------------------------------------------------
// bsmd_state
// Configuration registers and the seven display soft-switch flags.
// ----------------------------------------------------------------------------
module bsmd_state (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bsmd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                        i_cfg_wdata,
    input  logic                        i_update,
    input  bsmd_pkg::t_flags            i_flags_nxt,
    output bsmd_pkg::t_cfg              o_cfg,
    output bsmd_pkg::t_flags            o_flags
);
    import bsmd_pkg::*;

    t_cfg   r_cfg;
    t_cfg   n_cfg;
    t_flags r_flags;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_AUX_ZERO_PAGE: n_cfg.aux_zero_page = i_cfg_wdata;
                CFG_AUX_READ:      n_cfg.aux_read      = i_cfg_wdata;
                CFG_AUX_WRITE:     n_cfg.aux_write     = i_cfg_wdata;
                CFG_BANK_RAM_READ: n_cfg.bank_ram_read = i_cfg_wdata;
                CFG_BANK2_SELECT:  n_cfg.bank2_select  = i_cfg_wdata;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= '0;
            r_flags <= '0;
        end else begin
            r_cfg <= n_cfg;
            if (i_update) begin
                r_flags <= i_flags_nxt;
            end
        end
    end

    assign o_cfg   = r_cfg;
    assign o_flags = r_flags;

endmodule

/* src/bsmd_decode.sv */
// ----------------------------------------------------------------------------
// bsmd_decode
// Page decode to a region, soft-switch read mux and flag next-state.
// ----------------------------------------------------------------------------
module bsmd_decode (
    input  bsmd_pkg::t_item   i_item,
    input  bsmd_pkg::t_cfg    i_cfg,
    input  bsmd_pkg::t_flags  i_flags,
    output bsmd_pkg::t_result o_result,
    output bsmd_pkg::t_flags  o_flags_nxt
);
    import bsmd_pkg::*;

    logic [7:0] w_page;
    logic       w_wr;
    logic       w_aux_sel;
    logic       w_is_sw;
    logic [2:0] w_region;
    logic [7:0] w_rd;
    t_flags     w_flags;

    assign w_page    = i_item.address[15:8];
    assign w_wr      = (i_item.req_type == REQ_WRITE);
    assign w_aux_sel = w_wr ? i_cfg.aux_write : i_cfg.aux_read;

    always_comb begin
        if (w_page[7:1] == 7'h00) begin
            w_region = i_cfg.aux_zero_page ? RGN_AUX : RGN_MAIN;
        end else if (w_page[7:2] == 6'h01) begin
            // display pages also follow 80-store with page 2
            w_region = (w_aux_sel || (i_flags.store80 && i_flags.page2)) ? RGN_AUX
                                                                       : RGN_MAIN;
        end else if (w_page == 8'hC0) begin
            w_region = RGN_SWITCH;
        end else if (w_page[7:4] == 4'hC) begin
            w_region = RGN_SLOT;
        end else if (w_page[7:4] == 4'hD) begin
            if (i_cfg.bank_ram_read) begin
                w_region = i_cfg.bank2_select ? RGN_BANK2 : RGN_BANK1;
            end else begin
                w_region = RGN_ROM;
            end
        end else begin
            w_region = w_aux_sel ? RGN_AUX : RGN_MAIN;
        end
    end

    assign w_is_sw = (w_region == RGN_SWITCH);

    always_comb begin
        case (i_item.address)
            RD_VBLANK: w_rd = i_item.vblank_status;
            RD_TEXT:   w_rd = i_flags.text_mode ? STATUS_BIT : 8'h00;
            RD_MIXED:  w_rd = i_flags.mixed_mode ? STATUS_BIT : 8'h00;
            RD_ALTCH:  w_rd = i_flags.altchar ? STATUS_BIT : 8'h00;
            default:   w_rd = 8'h00;
        endcase
    end

    always_comb begin
        w_flags = i_flags;
        if (w_wr) begin
            case (i_item.address)
                SW_STORE80_OFF, SW_STORE80_ON: w_flags.store80    = i_item.address[0];
                SW_COL80_OFF, SW_COL80_ON:     w_flags.col80      = i_item.address[0];
                SW_ALTCH_OFF, SW_ALTCH_ON:     w_flags.altchar    = i_item.address[0];
                SW_TEXT_OFF, SW_TEXT_ON:       w_flags.text_mode  = i_item.address[0];
                SW_MIXED_OFF, SW_MIXED_ON:     w_flags.mixed_mode = i_item.address[0];
                SW_PAGE2_OFF, SW_PAGE2_ON:     w_flags.page2      = i_item.address[0];
                SW_HIRES_OFF, SW_HIRES_ON:     w_flags.hires      = i_item.address[0];
                default:                       w_flags = i_flags;
            endcase
        end
    end

    assign o_result.region    = w_region;
    assign o_result.mem_wdata = (w_wr && !w_is_sw) ? i_item.write_data : 8'h00;
    assign o_result.sw_rdata  = (!w_wr && w_is_sw) ? w_rd : 8'h00;
    assign o_flags_nxt        = w_flags;

endmodule

/* tb/sv/bsmd_access_checker.sv */
// ----------------------------------------------------------------------------
// bsmd_access_checker
// Watches both channels and the switch-register port of the decoder, keeps
// its own copy of the switches and display flags, predicts the decode of
// every accepted access and compares each delivered result in order.
// ----------------------------------------------------------------------------
module bsmd_access_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // access channel
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_req_type,
    input  logic [15:0]                    i_address,
    input  logic [7:0]                     i_write_data,
    input  logic [7:0]                     i_vblank_status,
    // result channel
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [2:0]                     i_region,
    input  logic [7:0]                     i_mem_wdata,
    input  logic [7:0]                     i_sw_rdata,
    input  bsmd_pkg::t_flags               i_flags,
    // switch registers
    input  logic                           i_cfg_we,
    input  logic [bsmd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                           i_cfg_wdata,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import bsmd_pkg::*;

    typedef struct packed {
        t_result res;
        t_flags  flags;
    } t_decode;

    t_cfg    bank_switches;
    t_flags  display_flags;
    t_decode pending_decodes[$];
    int      err_count;
    int      checked_count;

    task automatic report_error(string msg);
        $display("[%0t] decoder mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) begin
            report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    // Decode one access; soft-switch writes update the display flags, and the
    // flags reported are those after the access.
    function automatic t_decode decode_access(t_item acc);
        t_decode    d;
        logic [7:0] page;
        logic       wr;
        logic       aux_sel;
        d       = '0;
        page    = acc.address[15:8];
        wr      = (acc.req_type == REQ_WRITE);
        aux_sel = wr ? bank_switches.aux_write : bank_switches.aux_read;

        if (page <= 8'h01) begin
            d.res.region = bank_switches.aux_zero_page ? RGN_AUX : RGN_MAIN;
        end else if (page >= 8'h04 && page <= 8'h07) begin
            d.res.region = (aux_sel || (display_flags.store80 && display_flags.page2))
                           ? RGN_AUX : RGN_MAIN;
        end else if (page == 8'hC0) begin
            d.res.region = RGN_SWITCH;
        end else if (page >= 8'hC1 && page <= 8'hCF) begin
            d.res.region = RGN_SLOT;
        end else if (page >= 8'hD0 && page <= 8'hDF) begin
            if (bank_switches.bank_ram_read) begin
                d.res.region = bank_switches.bank2_select ? RGN_BANK2 : RGN_BANK1;
            end else begin
                d.res.region = RGN_ROM;
            end
        end else begin
            d.res.region = aux_sel ? RGN_AUX : RGN_MAIN;
        end

        if (d.res.region == RGN_SWITCH) begin
            if (wr) begin
                case (acc.address)
                    SW_STORE80_OFF, SW_STORE80_ON: display_flags.store80    = acc.address[0];
                    SW_COL80_OFF, SW_COL80_ON:     display_flags.col80      = acc.address[0];
                    SW_ALTCH_OFF, SW_ALTCH_ON:     display_flags.altchar    = acc.address[0];
                    SW_TEXT_OFF, SW_TEXT_ON:       display_flags.text_mode  = acc.address[0];
                    SW_MIXED_OFF, SW_MIXED_ON:     display_flags.mixed_mode = acc.address[0];
                    SW_PAGE2_OFF, SW_PAGE2_ON:     display_flags.page2      = acc.address[0];
                    SW_HIRES_OFF, SW_HIRES_ON:     display_flags.hires      = acc.address[0];
                    default: ;
                endcase
            end else begin
                case (acc.address)
                    RD_VBLANK: d.res.sw_rdata = acc.vblank_status;
                    RD_TEXT:   d.res.sw_rdata = display_flags.text_mode  ? STATUS_BIT : 8'h00;
                    RD_MIXED:  d.res.sw_rdata = display_flags.mixed_mode ? STATUS_BIT : 8'h00;
                    RD_ALTCH:  d.res.sw_rdata = display_flags.altchar    ? STATUS_BIT : 8'h00;
                    default:   d.res.sw_rdata = 8'h00;
                endcase
            end
        end else if (wr) begin
            d.res.mem_wdata = acc.write_data;
        end

        d.flags = display_flags;
        return d;
    endfunction

    always @(posedge i_clk) begin
        t_decode want;
        t_item   acc;
        if (!i_rst_n) begin
            bank_switches = '0;
            display_flags = '0;
            pending_decodes.delete();
            err_count     = 0;
            checked_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_AUX_ZERO_PAGE: bank_switches.aux_zero_page = i_cfg_wdata;
                    CFG_AUX_READ:      bank_switches.aux_read      = i_cfg_wdata;
                    CFG_AUX_WRITE:     bank_switches.aux_write     = i_cfg_wdata;
                    CFG_BANK_RAM_READ: bank_switches.bank_ram_read = i_cfg_wdata;
                    CFG_BANK2_SELECT:  bank_switches.bank2_select  = i_cfg_wdata;
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (pending_decodes.size() == 0) begin
                    report_error("result delivered with no access outstanding");
                end else begin
                    want = pending_decodes.pop_front();
                    check_field("target_region", int'(i_region), int'(want.res.region));
                    check_field("mem_write_data", int'(i_mem_wdata),
                                int'(want.res.mem_wdata));
                    check_field("switch_read_data", int'(i_sw_rdata),
                                int'(want.res.sw_rdata));
                    check_field("store80_flag", int'(i_flags.store80),
                                int'(want.flags.store80));
                    check_field("text_flag", int'(i_flags.text_mode),
                                int'(want.flags.text_mode));
                    check_field("mixed_flag", int'(i_flags.mixed_mode),
                                int'(want.flags.mixed_mode));
                    check_field("page2_flag", int'(i_flags.page2), int'(want.flags.page2));
                    check_field("hires_flag", int'(i_flags.hires), int'(want.flags.hires));
                    check_field("col80_flag", int'(i_flags.col80), int'(want.flags.col80));
                    check_field("altchar_flag", int'(i_flags.altchar),
                                int'(want.flags.altchar));
                    checked_count++;
                end
            end

            if (i_in_valid && !i_in_stall) begin
                acc.req_type      = i_req_type;
                acc.address       = i_address;
                acc.write_data    = i_write_data;
                acc.vblank_status = i_vblank_status;
                pending_decodes.insert(pending_decodes.size(), decode_access(acc));
            end
        end
        o_errors  <= err_count;
        o_pending <= pending_decodes.size();
        o_checked <= checked_count;
    end

endmodule

/* tb/sv/tb_bank_switched_memory_decoder.sv */
// ----------------------------------------------------------------------------
// tb_bank_switched_memory_decoder
// Drives bus accesses into the decoder: a directed pass over page edges and
// every soft switch, then random accesses under all 32 settings of the bank
// switches, with random idle and stall on both channels. The checker module
// predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_bank_switched_memory_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import bsmd_pkg::*;

    localparam int   CYCLE_LIMIT = 400000;
    localparam int   PHASE_ITEMS = 31;
    localparam int   MAX_IDLE    = 18;
    localparam logic REQ_READ    = ~REQ_WRITE;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_valid         = 1'b0;
    logic                 i_req_type      = 1'b0;
    logic [15:0]          i_address       = '0;
    logic [7:0]           i_write_data    = '0;
    logic [7:0]           i_vblank_status = '0;
    logic                 i_stall         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic                 i_cfg_wdata     = 1'b0;

    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_target_region;
    logic [7:0]  o_mem_write_data;
    logic [7:0]  o_switch_read_data;
    logic        o_store80_flag, o_text_flag, o_mixed_flag, o_page2_flag;
    logic        o_hires_flag, o_col80_flag, o_altchar_flag;

    int          bad_count;
    int          pending_count;
    int          checked_count;
    int          cycle_count  = 0;
    int          sent_count   = 0;
    bit          quiet_phase  = 1'b0;
    int unsigned rx_hold      = 0;
    int unsigned rx_draw;

    always #5 i_clk = ~i_clk;

    bank_switched_memory_decoder dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_req_type         (i_req_type),
        .i_address          (i_address),
        .i_write_data       (i_write_data),
        .i_vblank_status    (i_vblank_status),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_target_region    (o_target_region),
        .o_mem_write_data   (o_mem_write_data),
        .o_switch_read_data (o_switch_read_data),
        .o_store80_flag     (o_store80_flag),
        .o_text_flag        (o_text_flag),
        .o_mixed_flag       (o_mixed_flag),
        .o_page2_flag       (o_page2_flag),
        .o_hires_flag       (o_hires_flag),
        .o_col80_flag       (o_col80_flag),
        .o_altchar_flag     (o_altchar_flag),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    bsmd_access_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_req_type      (i_req_type),
        .i_address       (i_address),
        .i_write_data    (i_write_data),
        .i_vblank_status (i_vblank_status),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_region        (o_target_region),
        .i_mem_wdata     (o_mem_write_data),
        .i_sw_rdata      (o_switch_read_data),
        .i_flags         ({o_store80_flag, o_text_flag, o_mixed_flag, o_page2_flag,
                           o_hires_flag, o_col80_flag, o_altchar_flag}),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_errors        (bad_count),
        .o_pending       (pending_count),
        .o_checked       (checked_count)
    );

    function automatic int unsigned draw_idle();
        return quiet_phase ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // result side: stall for a drawn number of cycles after each result taken
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            i_stall <= (rx_hold != 1);
        end else if (o_valid && !i_stall) begin
            rx_draw = draw_idle();
            rx_hold <= rx_draw;
            i_stall <= (rx_draw != 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bank_switched_memory_decoder regression: fail");
            $finish;
        end
    end

    function automatic t_item bus_access(logic wr, logic [15:0] addr, logic [7:0] data,
                                         logic [7:0] vbl);
        t_item acc;
        acc.req_type      = wr;
        acc.address       = addr;
        acc.write_data    = data;
        acc.vblank_status = vbl;
        return acc;
    endfunction

    function automatic logic [15:0] switch_address(int unsigned k);
        case (k)
            0:       return SW_STORE80_OFF;
            1:       return SW_STORE80_ON;
            2:       return SW_COL80_OFF;
            3:       return SW_COL80_ON;
            4:       return SW_ALTCH_OFF;
            5:       return SW_ALTCH_ON;
            6:       return SW_TEXT_OFF;
            7:       return SW_TEXT_ON;
            8:       return SW_MIXED_OFF;
            9:       return SW_MIXED_ON;
            10:      return SW_PAGE2_OFF;
            11:      return SW_PAGE2_ON;
            12:      return SW_HIRES_OFF;
            13:      return SW_HIRES_ON;
            14:      return RD_VBLANK;
            15:      return RD_TEXT;
            16:      return RD_MIXED;
            default: return RD_ALTCH;
        endcase
    endfunction

    // Weighted toward the soft-switch page and the special page ranges so the
    // flags keep moving and the 80-store/page2 path into pages 04-07 is hit.
    function automatic t_item random_access();
        t_item acc;
        acc.req_type      = 1'($urandom_range(0, 1));
        acc.address       = 16'($urandom);
        acc.write_data    = 8'($urandom);
        acc.vblank_status = 8'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                acc.address[15:8] = 8'hC0;
                if ($urandom_range(0, 3) != 0) begin
                    acc.address = switch_address($urandom_range(0, 17));
                end
            end
            3:       acc.address[15:8] = 8'($urandom_range('h04, 'h07));
            4:       acc.address[15:8] = 8'($urandom_range('h00, 'h01));
            5:       acc.address[15:8] = 8'($urandom_range('hD0, 'hDF));
            6:       acc.address[15:8] = 8'($urandom_range('hC1, 'hCF));
            default: ;
        endcase
        return acc;
    endfunction

    // Called at a clock edge; returns at the edge where the item is taken.
    task automatic send_access(t_item acc);
        int unsigned gap;
        gap = draw_idle();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_req_type      <= acc.req_type;
        i_address       <= acc.address;
        i_write_data    <= acc.write_data;
        i_vblank_status <= acc.vblank_status;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic load_switches(t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_AUX_ZERO_PAGE;
        i_cfg_wdata <= c.aux_zero_page;
        @(posedge i_clk);
        i_cfg_index <= CFG_AUX_READ;
        i_cfg_wdata <= c.aux_read;
        @(posedge i_clk);
        i_cfg_index <= CFG_AUX_WRITE;
        i_cfg_wdata <= c.aux_write;
        @(posedge i_clk);
        i_cfg_index <= CFG_BANK_RAM_READ;
        i_cfg_wdata <= c.bank_ram_read;
        @(posedge i_clk);
        i_cfg_index <= CFG_BANK2_SELECT;
        i_cfg_wdata <= c.bank2_select;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // pending count is registered, so do not stop at the edge where it first reads zero
    task automatic wait_idle();
        do @(posedge i_clk); while (pending_count != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_access(bus_access(REQ_READ,  16'h0000, 8'h00, 8'h00));
        send_access(bus_access(REQ_WRITE, 16'h01FF, 8'hFF, 8'hFF));
        send_access(bus_access(REQ_WRITE, SW_STORE80_ON, 8'hFF, 8'h00));
        // 80-store alone does not move pages 04-07
        send_access(bus_access(REQ_READ,  16'h0400, 8'h00, 8'h00));
        send_access(bus_access(REQ_WRITE, SW_PAGE2_ON, 8'hFF, 8'h00));
        send_access(bus_access(REQ_WRITE, 16'h07FF, 8'hA5, 8'h00));
        send_access(bus_access(REQ_WRITE, SW_TEXT_ON, 8'h00, 8'h00));
        send_access(bus_access(REQ_WRITE, SW_MIXED_ON, 8'h00, 8'h00));
        send_access(bus_access(REQ_WRITE, SW_HIRES_ON, 8'h00, 8'h00));
        send_access(bus_access(REQ_WRITE, SW_COL80_ON, 8'h00, 8'h00));
        send_access(bus_access(REQ_WRITE, SW_ALTCH_ON, 8'h00, 8'h00));
        send_access(bus_access(REQ_READ,  RD_VBLANK, 8'h00, 8'hFF));
        send_access(bus_access(REQ_READ,  RD_TEXT, 8'hFF, 8'h7F));
        send_access(bus_access(REQ_READ,  RD_MIXED, 8'h00, 8'h00));
        send_access(bus_access(REQ_READ,  RD_ALTCH, 8'h00, 8'h00));
        // unassigned soft-switch read and write
        send_access(bus_access(REQ_READ,  16'hC000, 8'h00, 8'hFF));
        send_access(bus_access(REQ_WRITE, 16'hC0FF, 8'hFF, 8'h00));
        send_access(bus_access(REQ_READ,  16'hC100, 8'h00, 8'h00));
        send_access(bus_access(REQ_WRITE, 16'hCFFF, 8'h5A, 8'h00));
        // writes into ROM still report the region and forward the byte
        send_access(bus_access(REQ_READ,  16'hD000, 8'h00, 8'h00));
        send_access(bus_access(REQ_WRITE, 16'hDFFF, 8'h01, 8'h00));
        send_access(bus_access(REQ_READ,  16'hE000, 8'h00, 8'h00));
        send_access(bus_access(REQ_WRITE, 16'hFFFF, 8'h80, 8'h00));
        send_access(bus_access(REQ_WRITE, SW_PAGE2_OFF, 8'hFF, 8'h00));
        send_access(bus_access(REQ_WRITE, SW_TEXT_OFF, 8'hFF, 8'h00));
        i_valid <= 1'b0;
    endtask

    initial begin
        int unsigned phase;
        t_cfg        setting;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        // every combination of the five bank switches, all-clear and all-set included
        for (phase = 0; phase < 32; phase++) begin
            wait_idle();
            setting = t_cfg'(phase[4:0]);
            load_switches(setting);
            quiet_phase <= ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) send_access(random_access());
            i_valid <= 1'b0;
        end
        wait_idle();
        repeat (4) @(posedge i_clk);
        $display("%0d accesses sent, %0d results checked, %0d mismatches",
                 sent_count, checked_count, bad_count);
        $display("covered page edges, all soft switches and 32 bank switch settings");
        if (bad_count == 0) begin
            $display("bank_switched_memory_decoder regression: pass");
        end else begin
            $display("bank_switched_memory_decoder regression: fail");
        end
        $finish;
    end

endmodule
